[hdl/aasg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Annular arc segment generator package
// Shared widths, the segment transaction type and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package aasg_pkg;

  localparam int ANGLE_W         = 9;
  localparam int RADIUS_W        = 12;
  localparam int COUNT_W         = 6;
  localparam int COORD_W         = 29;
  localparam int MAG_W           = 17;
  localparam int QIDX_W          = 7;
  localparam int QUARTER_ENTRIES = 91;
  localparam int PRODUCT_W       = MAG_W + RADIUS_W;
  localparam int CORNERS         = 8;
  localparam int ANGLES          = 4;

  localparam logic [ANGLE_W-1:0] DEG_90  = ANGLE_W'(90);
  localparam logic [ANGLE_W-1:0] DEG_180 = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0] DEG_270 = ANGLE_W'(270);
  localparam logic [ANGLE_W-1:0] DEG_360 = ANGLE_W'(360);

  typedef logic [ANGLE_W-1:0]         angle_t;
  typedef logic [RADIUS_W-1:0]        radius_t;
  typedef logic [COUNT_W-1:0]         count_t;
  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic [MAG_W-1:0]           mag_t;
  typedef logic [QIDX_W-1:0]          qidx_t;
  typedef logic [PRODUCT_W-1:0]       product_t;

  typedef struct packed {
    angle_t  from_angle;
    angle_t  to_angle;
    radius_t outer_radius;
    radius_t inner_radius;
    logic    last_piece;
  } seg_t;

  typedef logic [QUARTER_ENTRIES-1:0][MAG_W-1:0] quarter_table_t;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
  localparam logic [63:0] RAD_PER_DEG_Q60 = PI_Q60 / 64'd180;

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // round(65536*sin(d degrees)) for d in 0..90, Horner form of the Taylor series
  function automatic mag_t quarter_sine(input int unsigned d);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = RAD_PER_DEG_Q60 * 64'(d);
    x2 = mul_q60(x, x);
    t  = ONE_Q60;
    t  = ONE_Q60 - mul_q60(t, x2) / 64'd342;
    t  = ONE_Q60 - mul_q60(t, x2) / 64'd272;
    t  = ONE_Q60 - mul_q60(t, x2) / 64'd210;
    t  = ONE_Q60 - mul_q60(t, x2) / 64'd156;
    t  = ONE_Q60 - mul_q60(t, x2) / 64'd110;
    t  = ONE_Q60 - mul_q60(t, x2) / 64'd72;
    t  = ONE_Q60 - mul_q60(t, x2) / 64'd42;
    t  = ONE_Q60 - mul_q60(t, x2) / 64'd20;
    t  = ONE_Q60 - mul_q60(t, x2) / 64'd6;
    s  = mul_q60(x, t);
    return MAG_W'((s + (64'd1 << 43)) >> 44);
  endfunction

  function automatic quarter_table_t build_quarter_table();
    quarter_table_t tbl;
    for (int i = 0; i < QUARTER_ENTRIES; i++) begin
      tbl[i] = quarter_sine(i);
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

[hdl/aasg_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Annular arc segment generator channels
// Arc command channel and quad result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface aasg_cmd_if;
  logic                  valid;
  logic                  ready;
  aasg_pkg::radius_t     outer_radius;
  aasg_pkg::radius_t     inner_radius;
  aasg_pkg::count_t      segment_count;
  aasg_pkg::angle_t      start_angle;
  aasg_pkg::angle_t      end_angle;

  modport source (output valid, output outer_radius, output inner_radius,
                  output segment_count, output start_angle, output end_angle,
                  input ready);
  modport sink   (input valid, input outer_radius, input inner_radius,
                  input segment_count, input start_angle, input end_angle,
                  output ready);
endinterface

interface aasg_quad_if;
  logic             valid;
  logic             ready;
  aasg_pkg::coord_t from_outer_x;
  aasg_pkg::coord_t from_outer_y;
  aasg_pkg::coord_t to_outer_x;
  aasg_pkg::coord_t to_outer_y;
  aasg_pkg::coord_t to_inner_x;
  aasg_pkg::coord_t to_inner_y;
  aasg_pkg::coord_t from_inner_x;
  aasg_pkg::coord_t from_inner_y;
  logic             last_piece;

  modport source (output valid, output from_outer_x, output from_outer_y,
                  output to_outer_x, output to_outer_y, output to_inner_x,
                  output to_inner_y, output from_inner_x, output from_inner_y,
                  output last_piece, input ready);
  modport sink   (input valid, input from_outer_x, input from_outer_y,
                  input to_outer_x, input to_outer_y, input to_inner_x,
                  input to_inner_y, input from_inner_x, input from_inner_y,
                  input last_piece, output ready);
endinterface

`default_nettype wire

[hdl/annular_arc_segment_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Annular arc segment generator
// Expands one arc command into segment_count + 1 ring quads.
//
//   channel  modport  transaction
//   cmd      sink     radii, segment count, start and end angle
//   quad     source   eight corner coordinates and last_piece flag
//
// A command is accepted, runs the serial span/count divider (skipped for a
// zero count), then issues one quad per cycle while the pipeline takes them.
// Quads leave a four-stage pipeline (cosine angle, table lookup, multiply,
// sign) at one per cycle while quad is ready.
// Synchronous reset clears all valid bits and returns the sequencer to idle.
// Back-pressure on quad holds each stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module annular_arc_segment_generator (
  input  wire logic clk,
  input  wire logic rst,
  aasg_cmd_if.sink  cmd,
  aasg_quad_if.source quad
);

  logic           seg_valid;
  logic           seg_ready;
  aasg_pkg::seg_t seg;

  aasg_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg)
  );

  aasg_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg),
    .quad      (quad)
  );

endmodule

`default_nettype wire

[hdl/aasg_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Annular arc segment sequencer
// Divides the span by the segment count unless it is zero, then steps the
// point angle once per segment transaction.
// ----------------------------------------------------------------------------
module aasg_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  aasg_cmd_if.sink            cmd,
  output logic                seg_valid,
  input  wire logic           seg_ready,
  output aasg_pkg::seg_t      seg
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam int         BIT_W  = $clog2(aasg_pkg::ANGLE_W);
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(aasg_pkg::ANGLE_W - 1);

  logic [1:0]              state;
  aasg_pkg::radius_t       ro;
  aasg_pkg::radius_t       ri;
  aasg_pkg::count_t        count;
  aasg_pkg::angle_t        start;
  aasg_pkg::angle_t        endpt;
  aasg_pkg::angle_t        dq;
  aasg_pkg::count_t        rem;
  logic [BIT_W-1:0]        bit_cnt;
  aasg_pkg::angle_t        q;
  aasg_pkg::count_t        r;
  aasg_pkg::count_t        k;
  aasg_pkg::angle_t        prev;

  aasg_pkg::angle_t        st_m;
  aasg_pkg::angle_t        en_m;
  logic [aasg_pkg::ANGLE_W:0] diff;
  aasg_pkg::angle_t        span;
  logic [aasg_pkg::COUNT_W:0] rem_sh;
  logic                    rem_ge;
  logic [aasg_pkg::ANGLE_W:0] cur_sum;
  aasg_pkg::angle_t        cur;
  logic [aasg_pkg::COUNT_W:0] r_sum;
  logic                    r_carry;
  logic                    last;
  logic                    emit;
  logic                    accept;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;

  always_comb begin
    st_m = (cmd.start_angle >= aasg_pkg::DEG_360) ?
           cmd.start_angle - aasg_pkg::DEG_360 : cmd.start_angle;
    en_m = (cmd.end_angle > aasg_pkg::DEG_360) ?
           cmd.end_angle - aasg_pkg::DEG_360 : cmd.end_angle;
    diff = {1'b0, en_m} - {1'b0, st_m};
    span = diff[aasg_pkg::ANGLE_W] ? diff[aasg_pkg::ANGLE_W-1:0] + aasg_pkg::DEG_360 :
           diff[aasg_pkg::ANGLE_W-1:0];
  end

  always_comb begin
    rem_sh  = {rem, dq[aasg_pkg::ANGLE_W-1]};
    rem_ge  = rem_sh >= {1'b0, count};
    cur_sum = {1'b0, start} + {1'b0, q};
    cur     = (cur_sum >= {1'b0, aasg_pkg::DEG_360}) ?
              aasg_pkg::ANGLE_W'(cur_sum - {1'b0, aasg_pkg::DEG_360}) :
              cur_sum[aasg_pkg::ANGLE_W-1:0];
    r_sum   = {1'b0, r} + {1'b0, rem};
    r_carry = r_sum >= {1'b0, count};
    last    = (k == count);
    emit    = (state == S_RUN) && (!seg_valid || seg_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seg_valid <= 1'b0;
    end else begin
      if (emit) begin
        seg_valid <= 1'b1;
      end else if (seg_ready) begin
        seg_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (cmd.segment_count == '0) ? S_RUN : S_DIV;
          end
        end
        S_DIV: begin
          if (bit_cnt == LAST_BIT) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (emit && last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ro      <= cmd.outer_radius;
      ri      <= cmd.inner_radius;
      count   <= cmd.segment_count;
      start   <= st_m;
      endpt   <= (en_m == aasg_pkg::DEG_360) ? '0 : en_m;
      dq      <= span;
      rem     <= '0;
      bit_cnt <= '0;
      q       <= '0;
      r       <= '0;
      k       <= '0;
      prev    <= st_m;
    end else if (state == S_DIV) begin
      rem     <= rem_ge ? aasg_pkg::COUNT_W'(rem_sh - {1'b0, count}) :
                 rem_sh[aasg_pkg::COUNT_W-1:0];
      dq      <= {dq[aasg_pkg::ANGLE_W-2:0], rem_ge};
      bit_cnt <= bit_cnt + 1'b1;
    end else if (emit) begin
      seg.from_angle   <= prev;
      seg.to_angle     <= last ? endpt : cur;
      seg.outer_radius <= ro;
      seg.inner_radius <= ri;
      seg.last_piece   <= last;
      prev             <= cur;
      r                <= r_carry ? aasg_pkg::COUNT_W'(r_sum - {1'b0, count}) :
                          r_sum[aasg_pkg::COUNT_W-1:0];
      q                <= q + dq + aasg_pkg::ANGLE_W'(r_carry);
      k                <= k + 1'b1;
    end
  end

endmodule

`default_nettype wire

[hdl/aasg_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Annular arc segment coordinate pipeline
// Four stages: cosine angles, quarter-wave lookup, radius multiply, sign.
// ----------------------------------------------------------------------------
module aasg_pipe (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           seg_valid,
  output logic                seg_ready,
  input  wire aasg_pkg::seg_t seg,
  aasg_quad_if.source         quad
);

  localparam aasg_pkg::quarter_table_t QUARTER_TABLE = aasg_pkg::build_quarter_table();

  typedef struct packed {
    aasg_pkg::qidx_t idx;
    logic            neg;
  } fold_t;

  function automatic aasg_pkg::angle_t cos_angle(input aasg_pkg::angle_t a);
    logic [aasg_pkg::ANGLE_W:0] s;
    s = {1'b0, a} + {1'b0, aasg_pkg::DEG_90};
    if (s >= {1'b0, aasg_pkg::DEG_360}) begin
      s = s - {1'b0, aasg_pkg::DEG_360};
    end
    return s[aasg_pkg::ANGLE_W-1:0];
  endfunction

  function automatic fold_t fold(input aasg_pkg::angle_t a);
    fold_t f;
    if (a <= aasg_pkg::DEG_90) begin
      f.idx = aasg_pkg::QIDX_W'(a);
      f.neg = 1'b0;
    end else if (a <= aasg_pkg::DEG_180) begin
      f.idx = aasg_pkg::QIDX_W'(aasg_pkg::DEG_180 - a);
      f.neg = 1'b0;
    end else if (a <= aasg_pkg::DEG_270) begin
      f.idx = aasg_pkg::QIDX_W'(a - aasg_pkg::DEG_180);
      f.neg = 1'b1;
    end else begin
      f.idx = aasg_pkg::QIDX_W'(aasg_pkg::DEG_360 - a);
      f.neg = 1'b1;
    end
    return f;
  endfunction

  logic               v1, v2, v3, v4;
  logic               adv1, adv2, adv3, adv4;
  aasg_pkg::angle_t   ang1 [aasg_pkg::ANGLES];
  aasg_pkg::radius_t  ro1, ri1, ro2, ri2;
  logic               last1, last2, last3, last4;
  aasg_pkg::mag_t     mag2 [aasg_pkg::ANGLES];
  logic               neg2 [aasg_pkg::ANGLES];
  aasg_pkg::product_t prod3 [aasg_pkg::CORNERS];
  logic               neg3 [aasg_pkg::CORNERS];
  aasg_pkg::coord_t   coord4 [aasg_pkg::CORNERS];

  assign adv4      = !v4 || quad.ready;
  assign adv3      = !v3 || adv4;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign seg_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= seg_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && seg_valid) begin
      ang1[0] <= seg.from_angle;
      ang1[1] <= cos_angle(seg.from_angle);
      ang1[2] <= seg.to_angle;
      ang1[3] <= cos_angle(seg.to_angle);
      ro1     <= seg.outer_radius;
      ri1     <= seg.inner_radius;
      last1   <= seg.last_piece;
    end
  end

  for (genvar a = 0; a < aasg_pkg::ANGLES; a++) begin : g_lookup
    fold_t f;
    assign f = fold(ang1[a]);
    always_ff @(posedge clk) begin
      if (adv2 && v1) begin
        mag2[a] <= QUARTER_TABLE[f.idx];
        neg2[a] <= f.neg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      ro2   <= ro1;
      ri2   <= ri1;
      last2 <= last1;
    end
    if (adv3 && v2) begin
      last3 <= last2;
    end
    if (adv4 && v3) begin
      last4 <= last3;
    end
  end

  // corner order: from outer, to outer, to inner, from inner; x then y
  for (genvar j = 0; j < aasg_pkg::CORNERS; j++) begin : g_corner
    localparam int AI = (j < 4) ? j : ((j < 6) ? j - 2 : j - 6);
    aasg_pkg::radius_t rad;
    assign rad = (j < 4) ? ro2 : ri2;
    always_ff @(posedge clk) begin
      if (adv3 && v2) begin
        prod3[j] <= aasg_pkg::PRODUCT_W'(mag2[AI]) * aasg_pkg::PRODUCT_W'(rad);
        neg3[j]  <= neg2[AI];
      end
      if (adv4 && v3) begin
        coord4[j] <= neg3[j] ? aasg_pkg::coord_t'(aasg_pkg::COORD_W'(0) - prod3[j]) :
                     aasg_pkg::coord_t'(prod3[j]);
      end
    end
  end

  assign quad.valid        = v4;
  assign quad.from_outer_x = coord4[0];
  assign quad.from_outer_y = coord4[1];
  assign quad.to_outer_x   = coord4[2];
  assign quad.to_outer_y   = coord4[3];
  assign quad.to_inner_x   = coord4[4];
  assign quad.to_inner_y   = coord4[5];
  assign quad.from_inner_x = coord4[6];
  assign quad.from_inner_y = coord4[7];
  assign quad.last_piece   = last4;

endmodule

`default_nettype wire

[tb/sv/annular_arc_segment_generator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Annular arc segment generator testbench
// Drives arc commands and checks every quad against a predictor built on a
// 360-entry sine table. Covers directed corner arcs, random traffic with
// random gaps on both channels, back-to-back traffic, output stalls that fill
// the block and pauses that let it drain completely.
// ----------------------------------------------------------------------------
module annular_arc_segment_generator_test;

  localparam int  FULL_TURN    = 360;
  localparam int  STALL_CYCLES = 600;
  localparam int  TAIL_CYCLES  = 20;
  localparam int  CYCLE_LIMIT  = 4000000;
  localparam real PI_REAL      = 3.14159265358979323846;

  typedef struct packed {
    aasg_pkg::radius_t outer_radius;
    aasg_pkg::radius_t inner_radius;
    aasg_pkg::count_t  segment_count;
    aasg_pkg::angle_t  start_angle;
    aasg_pkg::angle_t  end_angle;
  } arc_cmd_t;

  typedef struct packed {
    aasg_pkg::coord_t from_outer_x;
    aasg_pkg::coord_t from_outer_y;
    aasg_pkg::coord_t to_outer_x;
    aasg_pkg::coord_t to_outer_y;
    aasg_pkg::coord_t to_inner_x;
    aasg_pkg::coord_t to_inner_y;
    aasg_pkg::coord_t from_inner_x;
    aasg_pkg::coord_t from_inner_y;
    logic             last_piece;
  } ring_quad_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aasg_cmd_if  cmd ();
  aasg_quad_if quad ();

  annular_arc_segment_generator u_top (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .quad (quad)
  );

  int         sine_deg [0:FULL_TURN-1];
  ring_quad_t expected_quads [$];
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         src_idle = 1'b1;
  bit         sink_idle = 1'b1;
  bit         sink_hold = 1'b0;
  event       sink_stall_go;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void build_sine_table();
    int q [0:90];
    for (int d = 0; d <= 90; d++) begin
      q[d] = $rtoi(65536.0 * $sin(d * PI_REAL / 180.0) + 0.5);
    end
    for (int d = 0; d < FULL_TURN; d++) begin
      if (d <= 90) begin
        sine_deg[d] = q[d];
      end else if (d <= 180) begin
        sine_deg[d] = q[180 - d];
      end else if (d <= 270) begin
        sine_deg[d] = -q[d - 180];
      end else begin
        sine_deg[d] = -q[360 - d];
      end
    end
  endfunction

  function automatic aasg_pkg::coord_t ring_coord(int deg, int radius);
    return aasg_pkg::coord_t'(sine_deg[deg % FULL_TURN] * radius);
  endfunction

  function automatic ring_quad_t ring_quad(int from_deg, int to_deg, int ro, int ri,
                                           bit last);
    ring_quad_t q;
    int         from_cos;
    int         to_cos;
    from_cos       = (from_deg + 90) % FULL_TURN;
    to_cos         = (to_deg + 90) % FULL_TURN;
    q.from_outer_x = ring_coord(from_deg, ro);
    q.from_outer_y = ring_coord(from_cos, ro);
    q.to_outer_x   = ring_coord(to_deg, ro);
    q.to_outer_y   = ring_coord(to_cos, ro);
    q.to_inner_x   = ring_coord(to_deg, ri);
    q.to_inner_y   = ring_coord(to_cos, ri);
    q.from_inner_x = ring_coord(from_deg, ri);
    q.from_inner_y = ring_coord(from_cos, ri);
    q.last_piece   = last;
    return q;
  endfunction

  function automatic void predict_arc(arc_cmd_t a);
    int ro;
    int ri;
    int n;
    int st;
    int en;
    int span;
    int prev;
    int cur;
    ro = a.outer_radius;
    ri = a.inner_radius;
    n  = a.segment_count;
    st = a.start_angle % FULL_TURN;
    en = a.end_angle;
    if (en > FULL_TURN) begin
      en = en % FULL_TURN;
    end
    span = en - st;
    if (span < 0) begin
      span += FULL_TURN;
    end
    prev = st;
    for (int k = 0; k < n; k++) begin
      cur = (st + (span * k) / n) % FULL_TURN;
      expected_quads.push_back(ring_quad(prev, cur, ro, ri, 1'b0));
      prev = cur;
    end
    expected_quads.push_back(ring_quad(prev, en % FULL_TURN, ro, ri, 1'b1));
  endfunction

  function automatic arc_cmd_t make_arc(int ro, int ri, int n, int s, int e);
    arc_cmd_t a;
    a.outer_radius  = aasg_pkg::radius_t'(ro);
    a.inner_radius  = aasg_pkg::radius_t'(ri);
    a.segment_count = aasg_pkg::count_t'(n);
    a.start_angle   = aasg_pkg::angle_t'(s);
    a.end_angle     = aasg_pkg::angle_t'(e);
    return a;
  endfunction

  function automatic int random_radius();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 4095;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic arc_cmd_t random_arc();
    int pick;
    int n;
    int s;
    int e;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      n = $urandom_range(0, 15);
    end else if (pick < 90) begin
      n = $urandom_range(16, 47);
    end else begin
      n = $urandom_range(48, 63);
    end
    s = ($urandom_range(0, 9) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      e = $urandom_range(361, 511);
    end else if (pick < 5) begin
      e = s % FULL_TURN;
    end else begin
      e = $urandom_range(0, 360);
    end
    return make_arc(random_radius(), random_radius(), n, s, e);
  endfunction

  task automatic send_arc(input arc_cmd_t a);
    int gap;
    gap = src_idle ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.outer_radius  <= a.outer_radius;
    cmd.inner_radius  <= a.inner_radius;
    cmd.segment_count <= a.segment_count;
    cmd.start_angle   <= a.start_angle;
    cmd.end_angle     <= a.end_angle;
    cmd.valid         <= 1'b1;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    predict_arc(a);
  endtask

  task automatic wait_arcs_done();
    @(negedge clk);
    cmd.valid <= 1'b0;
    while (expected_quads.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed_arcs();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_arc(make_arc(4095, 4095, 0, 0, 0));
    send_arc(make_arc(4095, 0, 63, 0, 360));
    send_arc(make_arc(0, 4095, 1, 359, 0));
    send_arc(make_arc(4095, 4095, 63, 359, 360));
    send_arc(make_arc(1, 2, 4, 90, 90));
    send_arc(make_arc(4095, 2048, 7, 300, 60));
    send_arc(make_arc(100, 50, 3, 360, 10));
    send_arc(make_arc(4095, 4095, 5, 511, 511));
    send_arc(make_arc(2000, 1000, 9, 10, 361));
    send_arc(make_arc(4095, 4095, 63, 0, 1));
    send_arc(make_arc(0, 0, 2, 180, 270));
    send_arc(make_arc(4095, 1, 6, 45, 315));
    send_arc(make_arc(2730, 1365, 63, 1, 359));
    send_arc(make_arc(4095, 4095, 0, 270, 90));
    send_arc(make_arc(3000, 3000, 1, 0, 360));
    send_arc(make_arc(1234, 4095, 12, 0, 180));
    send_arc(make_arc(4095, 4095, 32, 359, 358));
    wait_arcs_done();
  endtask

  task automatic test_random_traffic();
    for (int chunk = 0; chunk < 6; chunk++) begin
      src_idle  = (chunk == 0) ? 1'b1 : (chunk == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      sink_idle = (chunk == 0) ? 1'b1 : (chunk == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      for (int i = 0; i < 50; i++) begin
        send_arc(random_arc());
      end
    end
    wait_arcs_done();
  endtask

  task automatic test_back_to_back();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    for (int i = 0; i < 80; i++) begin
      send_arc(random_arc());
    end
    wait_arcs_done();
  endtask

  task automatic test_output_stall();
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    -> sink_stall_go;
    for (int i = 0; i < 10; i++) begin
      send_arc(make_arc(random_radius(), random_radius(), 63, $urandom_range(0, 359),
                        $urandom_range(0, 360)));
    end
    wait_arcs_done();
  endtask

  task automatic test_drain_pauses();
    for (int round = 0; round < 8; round++) begin
      src_idle  = 1'($urandom_range(0, 1));
      sink_idle = 1'($urandom_range(0, 1));
      for (int i = 0; i < 10; i++) begin
        send_arc(random_arc());
      end
      wait_arcs_done();
    end
  endtask

  initial begin
    while (rst) @(negedge clk);
    forever begin : accept_quads
      int hold;
      @(negedge clk);
      hold = sink_idle ? $urandom_range(0, 19) : 0;
      if (hold > 0 || sink_hold) begin
        quad.ready <= 1'b0;
        repeat (hold) @(negedge clk);
        while (sink_hold) @(negedge clk);
      end
      quad.ready <= 1'b1;
      do @(posedge clk); while (quad.valid !== 1'b1);
    end
  end

  initial begin
    forever begin
      @(sink_stall_go);
      @(posedge clk);
      sink_hold = 1'b1;
      repeat (STALL_CYCLES) @(posedge clk);
      sink_hold = 1'b0;
    end
  end

  function automatic void check_field(string field, aasg_pkg::coord_t want,
                                      aasg_pkg::coord_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_quads
    ring_quad_t want;
    if (!rst && quad.valid === 1'b1 && quad.ready === 1'b1) begin
      if (expected_quads.size() == 0) begin
        $error("quad transaction with no pending arc");
        mismatches++;
      end else begin
        want = expected_quads.pop_front();
        check_field("from_outer_x", want.from_outer_x, quad.from_outer_x);
        check_field("from_outer_y", want.from_outer_y, quad.from_outer_y);
        check_field("to_outer_x", want.to_outer_x, quad.to_outer_x);
        check_field("to_outer_y", want.to_outer_y, quad.to_outer_y);
        check_field("to_inner_x", want.to_inner_x, quad.to_inner_x);
        check_field("to_inner_y", want.to_inner_y, quad.to_inner_y);
        check_field("from_inner_x", want.from_inner_x, quad.from_inner_x);
        check_field("from_inner_y", want.from_inner_y, quad.from_inner_y);
        check_field("last_piece", aasg_pkg::coord_t'(want.last_piece),
                    aasg_pkg::coord_t'(quad.last_piece));
      end
    end
  end

  initial begin
    cmd.valid         = 1'b0;
    cmd.outer_radius  = '0;
    cmd.inner_radius  = '0;
    cmd.segment_count = '0;
    cmd.start_angle   = '0;
    cmd.end_angle     = '0;
    quad.ready        = 1'b0;
    build_sine_table();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_directed_arcs();
    test_random_traffic();
    test_back_to_back();
    test_output_stall();
    test_drain_pauses();

    wait_arcs_done();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_quads.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
